// File: design/lsb4se_pkg.sv
// Shared types, codes and defaults for the LSB4 stream extractor.
`default_nettype none

package lsb4se_pkg;

  localparam int unsigned MAX_EXT_LEN_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [31:0] HEADER_BYTES    = 32'd4;

  // Section codes as they appear on the result stream.
  localparam logic [1:0] SEC_HEADER = 2'd0;
  localparam logic [1:0] SEC_DATA   = 2'd1;
  localparam logic [1:0] SEC_EXT    = 2'd2;

  // One assembled stream byte, with a flag that clears progress before it is used.
  typedef struct packed {
    logic       clr;
    logic [7:0] data;
  } item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] section;
    logic       last;
    logic       overrun;
  } result_t;

  typedef enum logic [3:0] {
    ST_HEADER = 4'b0001,
    ST_DATA   = 4'b0010,
    ST_EXT    = 4'b0100,
    ST_DONE   = 4'b1000
  } stream_state_e;

endpackage

`default_nettype wire

// File: design/lsb4se_front.sv
// Front end: pairs component nibbles into stream bytes and tracks restarts.
`default_nettype none

module lsb4se_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       component_i,
  input  wire logic             restart_i,
  output lsb4se_pkg::item_t     item_o,
  output logic                  push_o
);
  import lsb4se_pkg::*;

  logic       phase_q, phase_d;
  logic [3:0] high_q, high_d;
  logic       pend_clr_q, pend_clr_d;
  logic       phase_eff;
  logic       clr_eff;

  // A restart drops any half-built byte; its clear travels with the next byte.
  assign phase_eff = restart_i ? 1'b0 : phase_q;
  assign clr_eff   = restart_i | pend_clr_q;

  always_comb begin
    phase_d     = phase_q;
    high_d      = high_q;
    pend_clr_d  = pend_clr_q;
    push_o      = 1'b0;
    item_o.clr  = clr_eff;
    item_o.data = {high_q, component_i[3:0]};
    if (accept_i) begin
      if (!phase_eff) begin
        high_d     = component_i[3:0];
        phase_d    = 1'b1;
        pend_clr_d = clr_eff;
      end else begin
        push_o     = 1'b1;
        phase_d    = 1'b0;
        pend_clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      high_q     <= 4'd0;
      pend_clr_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      high_q     <= high_d;
      pend_clr_q <= pend_clr_d;
    end
  end

endmodule

`default_nettype wire

// File: design/lsb4se_fifo.sv
// Short byte queue between the front end and the stream parser.
`default_nettype none

module lsb4se_fifo #(
  parameter int unsigned Depth = lsb4se_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  lsb4se_pkg::item_t      push_item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output lsb4se_pkg::item_t      head_o
);
  import lsb4se_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: design/lsb4se_back.sv
// Back end: walks header, data and extension sections and registers each result.
`default_nettype none

module lsb4se_back #(
  parameter int unsigned MaxExtLen = lsb4se_pkg::MAX_EXT_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              encrypted_mode_i,
  input  wire logic              item_valid_i,
  input  lsb4se_pkg::item_t      item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output lsb4se_pkg::result_t    out_o,
  input  wire logic              out_ready_i
);
  import lsb4se_pkg::*;

  localparam logic [31:0] ExtLimit = 32'(MaxExtLen);

  stream_state_e state_q, state_d, base_state;
  logic [31:0]   cnt_q, cnt_d, base_cnt, cnt_inc;
  logic [31:0]   len_q, len_d, base_len, len_shift;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, res;
  logic          emit;
  logic          can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign pop_o       = item_valid_i && can_load;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Apply the carried restart before the byte is interpreted.
  assign base_state = item_i.clr ? ST_HEADER : state_q;
  assign base_cnt   = item_i.clr ? 32'd0 : cnt_q;
  assign base_len   = item_i.clr ? 32'd0 : len_q;
  assign cnt_inc    = base_cnt + 32'd1;
  assign len_shift  = {base_len[23:0], item_i.data};

  always_comb begin
    state_d     = base_state;
    cnt_d       = cnt_inc;
    len_d       = base_len;
    emit        = 1'b1;
    res.data    = item_i.data;
    res.section = SEC_HEADER;
    res.last    = 1'b0;
    res.overrun = 1'b0;
    unique case (base_state)
      ST_HEADER: begin
        len_d = len_shift;
        if (cnt_inc >= HEADER_BYTES) begin
          cnt_d = 32'd0;
          if (len_shift != 32'd0) begin
            state_d = ST_DATA;
          end else if (encrypted_mode_i) begin
            state_d  = ST_DONE;
            res.last = 1'b1;
          end else begin
            state_d = ST_EXT;
          end
        end
      end
      ST_DATA: begin
        res.section = SEC_DATA;
        if (cnt_inc >= base_len) begin
          cnt_d = 32'd0;
          if (encrypted_mode_i) begin
            state_d  = ST_DONE;
            res.last = 1'b1;
          end else begin
            state_d = ST_EXT;
          end
        end
      end
      ST_EXT: begin
        res.section = SEC_EXT;
        if (item_i.data == 8'd0) begin
          state_d  = ST_DONE;
          res.last = 1'b1;
        end else if (cnt_inc >= ExtLimit) begin
          state_d     = ST_DONE;
          res.last    = 1'b1;
          res.overrun = 1'b1;
        end
      end
      ST_DONE: begin
        // Drop bytes past the end of the stream.
        emit  = 1'b0;
        cnt_d = base_cnt;
      end
      default: begin
        emit    = 1'b0;
        state_d = ST_DONE;
        cnt_d   = base_cnt;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEADER;
      cnt_q       <= 32'd0;
      len_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: design/lsb4_stream_extractor_unit.sv
// Top level of the LSB4 stream extractor: ports, mode register and the three stages.
`default_nettype none

// Recovers a byte stream hidden in the low four bits of carrier color components.
// Feed components (blue, green, red per pixel, pixels in raster order) on the slave
// stream; every second component completes a byte, high nibble first. The stream is a
// 4-byte big-endian size, that many data bytes, then, unless encrypted mode is set, a
// NUL-terminated extension of at most MaxExtLen bytes (hitting the limit without a NUL
// ends the stream with the overrun flag). Each stream byte leaves as one request on
// the master stream tagged with its section; components after the end are dropped
// until a request with the restart flag. Rate: one component per clock while the
// queue has room. The front end pairs nibbles and writes the completed byte into a
// QueueDepth-entry queue at the edge that accepts its second component; the parser
// pops it when the output register is free or being read and loads it there, from
// which the byte shows on the master side.
// Write encrypted mode only while the block is idle.
module lsb4_stream_extractor_unit #(
  parameter int unsigned MaxExtLen  = lsb4se_pkg::MAX_EXT_LEN_DEF,
  parameter int unsigned QueueDepth = lsb4se_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Mode register write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,      // encrypted_mode
  // Carrier components in.
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // [7:0] component
  input  wire logic       s_axis_tuser,    // [0] restart
  // Stream bytes out.
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,    // [1:0] section, [2] overrun
  output logic            m_axis_tlast     // last byte of the hidden stream
);
  import lsb4se_pkg::*;

  logic    encrypted_mode_q;
  logic    in_accept;
  logic    fifo_full;
  logic    push;
  item_t   push_item;
  logic    fifo_valid;
  item_t   head;
  logic    pop;
  result_t result;

  // Mode register takes a write every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encrypted_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      encrypted_mode_q <= cfg_data_i;
    end
  end

  // Hold off the source only when the queue is full.
  assign s_axis_tready = !fifo_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lsb4se_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .component_i (s_axis_tdata),
    .restart_i   (s_axis_tuser),
    .item_o      (push_item),
    .push_o      (push)
  );

  lsb4se_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .head_o      (head)
  );

  lsb4se_back #(
    .MaxExtLen (MaxExtLen)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .encrypted_mode_i (encrypted_mode_q),
    .item_valid_i     (fifo_valid),
    .item_i           (head),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_o            (result),
    .out_ready_i      (m_axis_tready)
  );

  assign m_axis_tdata = result.data;
  assign m_axis_tuser = {result.overrun, result.section};
  assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

// File: design/lsb4se_checker.sv
// Port-level checks for the LSB4 stream extractor, bound to its top level.
`default_nettype none

module lsb4se_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  import lsb4se_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Section code is never the unused value.
  a_section_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] == SEC_HEADER || m_axis_tuser[1:0] == SEC_DATA
                       || m_axis_tuser[1:0] == SEC_EXT))
    else $error("invalid section code");

  // Overrun only ends an extension.
  a_overrun_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && m_axis_tuser[1:0] == SEC_EXT)
    else $error("overrun outside final extension byte");

  // An extension byte of zero always ends the stream.
  a_nul_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == SEC_EXT && m_axis_tdata == 8'd0
      |-> m_axis_tlast && !m_axis_tuser[2])
    else $error("extension NUL not marked last");

endmodule

bind lsb4_stream_extractor_unit lsb4se_checker u_checker (.*);

`default_nettype wire

// File: verif/lsb4_stream_extractor_checker.sv
// Checker for the LSB4 stream extractor: predicts stream bytes and compares results.
`timescale 1ns / 1ps

module lsb4_stream_extractor_checker #(
  parameter int unsigned MaxExtLen = lsb4se_pkg::MAX_EXT_LEN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_ready_i,
  input  wire logic       cfg_data_i,
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // [7:0] component
  input  wire logic       s_axis_tuser,    // [0] restart
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,    // [7:0] out_byte
  input  wire logic [2:0] m_axis_tuser,    // [1:0] section, [2] overrun
  input  wire logic       m_axis_tlast,
  output int              fail_count_o,
  output int              pending_o
);

  import lsb4se_pkg::*;

  logic        encrypt_mode;
  logic        pair_phase;
  logic [3:0]  upper_nibble;
  logic [1:0]  cur_section;
  logic [31:0] section_count;
  logic [31:0] payload_len;
  logic        stream_done;

  result_t expected_bytes[$];

  function automatic void clear_progress();
    pair_phase    = 1'b0;
    upper_nibble  = '0;
    cur_section   = SEC_HEADER;
    section_count = '0;
    payload_len   = '0;
    stream_done   = 1'b0;
  endfunction

  // Step past the data bytes; returns 1 when the stream ends here.
  function automatic logic leave_data();
    if (encrypt_mode) begin
      stream_done = 1'b1;
      return 1'b1;
    end
    cur_section   = SEC_EXT;
    section_count = '0;
    return 1'b0;
  endfunction

  task automatic absorb_component(input logic [7:0] comp, input logic restart);
    result_t    res;
    logic [7:0] b;
    if (restart) clear_progress();
    if (!stream_done && cur_section <= SEC_EXT) begin
      if (!pair_phase) begin
        upper_nibble = comp[3:0];
        pair_phase   = 1'b1;
      end else begin
        pair_phase  = 1'b0;
        b           = {upper_nibble, comp[3:0]};
        res.data    = b;
        res.section = cur_section;
        res.last    = 1'b0;
        res.overrun = 1'b0;
        case (cur_section)
          SEC_HEADER: begin
            payload_len = {payload_len[23:0], b};
            section_count++;
            if (section_count >= HEADER_BYTES) begin
              if (payload_len == 0) begin
                res.last = leave_data();
              end else begin
                cur_section   = SEC_DATA;
                section_count = '0;
              end
            end
          end
          SEC_DATA: begin
            section_count++;
            if (section_count >= payload_len) res.last = leave_data();
          end
          default: begin
            section_count++;
            if (b == 8'h00) begin
              res.last    = 1'b1;
              stream_done = 1'b1;
            end else if (section_count >= MaxExtLen) begin
              res.last    = 1'b1;
              res.overrun = 1'b1;
              stream_done = 1'b1;
            end
          end
        endcase
        expected_bytes.push_back(res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      encrypt_mode = 1'b0;
      clear_progress();
      expected_bytes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare each accepted result with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got.data    = m_axis_tdata;
        got.section = m_axis_tuser[1:0];
        got.last    = m_axis_tlast;
        got.overrun = m_axis_tuser[2];
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result data=%h section=%0d last=%b overrun=%b",
                   $time, got.data, got.section, got.last, got.overrun);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data || got.section !== want.section ||
              got.last !== want.last || got.overrun !== want.overrun) begin
            $display("%0t: mismatch expected data=%h section=%0d last=%b overrun=%b",
                     $time, want.data, want.section, want.last, want.overrun);
            $display("%0t:          actual   data=%h section=%0d last=%b overrun=%b",
                     $time, got.data, got.section, got.last, got.overrun);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) encrypt_mode = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) absorb_component(s_axis_tdata, s_axis_tuser);
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// File: verif/lsb4_stream_extractor_unit_test.sv
// Testbench top for the LSB4 stream extractor: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module lsb4_stream_extractor_unit_test;

  import lsb4se_pkg::*;

  localparam int unsigned ExtLimit = MAX_EXT_LEN_DEF;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int fail_count;
  int pending;

  // Sender bookkeeping.
  int unsigned burst_left = 0;
  int unsigned sent_items = 0;
  logic        mode_now   = 1'b0;
  bit          hold_req   = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lsb4_stream_extractor_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lsb4_stream_extractor_checker #(.MaxExtLen(ExtLimit)) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Offer one component request; enter and leave at a falling edge. Between bursts
  // drop tvalid for a random gap, except while the receiver is held off.
  task automatic send_item(input logic [7:0] comp, input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      if (!hold_req) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= comp;
    s_axis_tuser  <= restart;
    burst_left--;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Split a stream byte over two components, high nibble first, with random upper bits.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    send_item({4'($urandom), b[7:4]}, restart);
    send_item({4'($urandom), b[3:0]}, 1'b0);
    sent_items += 2;
  endtask

  // Hold off new requests until every predicted byte has left and the pipe is drained.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_now = m;
  endtask

  // Build one hidden stream and feed it; optionally cut it short to break the sequence.
  task automatic send_stream(input logic [31:0] size, input int unsigned ext_chars,
                             input bit cut_short);
    logic [7:0]  stream_q[$];
    int unsigned stop_at;
    for (int i = 3; i >= 0; i--) stream_q.push_back(size[i*8 +: 8]);
    repeat (size) stream_q.push_back(8'($urandom));
    if (!mode_now) begin
      repeat (ext_chars) stream_q.push_back(8'($urandom_range(1, 255)));
      if (ext_chars < ExtLimit) stream_q.push_back(8'h00);
    end
    stop_at = cut_short ? $urandom_range(1, stream_q.size()) : stream_q.size();
    for (int unsigned i = 0; i < stop_at; i++) send_byte(stream_q[i], i == 0);
    // Trailing components after a complete stream are dropped by the block.
    repeat ($urandom_range(0, 3)) send_item(8'($urandom), 1'b0);
  endtask

  // Receiver: stall on one of four patterns, picked anew at random at regular intervals, and
  // honor a long hold-off request by counting cycles here.
  initial begin
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_req = 1'b0;
      end
      cyc++;
      if (cyc % 250 == 0) style = $urandom_range(0, 3);
      case (style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom);
        2: m_axis_tready <= (cyc % 4) != 0;
        default: m_axis_tready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  initial begin
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Encrypted mode, zero size: the fourth header byte ends the stream, then
    // components without restart are dropped.
    write_mode(1'b1);
    send_item(8'hF0, 1'b1);
    repeat (7) send_item(8'hF0, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h0F, 1'b0);

    // Plain mode: restart in the middle of a header, then zero size with an empty
    // extension so the NUL is the only extension byte.
    write_mode(1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    repeat (7) send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    drain();

    sent_items = 0;
    for (int unsigned n = 0; sent_items < 600; n++) begin
      logic [31:0] size;
      int unsigned ext_chars;
      bit          cut_short;
      if (n % 6 == 5) write_mode(1'($urandom));
      else if ($urandom_range(0, 4) == 0) drain();
      // Hold off the receiver once while requests keep flowing to fill the block.
      if (n == 3) hold_req = 1'b1;
      size      = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      ext_chars = ($urandom_range(0, 4) == 0) ? ExtLimit : $urandom_range(0, ExtLimit - 1);
      cut_short = $urandom_range(0, 7) == 0;
      send_stream(size, ext_chars, cut_short);
      // Noise: random components, some with restart.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_item(8'($urandom), 1'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
